// ----- sv/fpa_pkg.sv -----
// Package: shared constants, opcodes, queue entry type and result type for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PORT_W         = 32;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_MIN = 4'd10;
    localparam logic [3:0] OP_MAX = 4'd11;
    localparam logic [3:0] OP_INC = 4'd12;
    localparam logic [3:0] OP_DEC = 4'd13;
    localparam logic [3:0] OP_I2F = 4'd14;
    localparam logic [3:0] OP_F2I = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic        is_div;
        logic        is_cmp;
        logic [PORT_W-1:0] a;
        logic [PORT_W-1:0] b;
    } t_op;

    typedef struct packed {
        logic [PORT_W-1:0] result;
        logic              cmp;
        logic              dz;
        logic              ovf;
    } t_res;
endpackage
`default_nettype wire

// ----- sv/fpa_front.sv -----
// Front end: accept transactions, sign-extend operands, classify, and queue them.
`default_nettype none
module fpa_front #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH_LOG2 = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [3:0]       i_kind,
    input  wire logic [31:0]      i_operand_a,
    input  wire logic [31:0]      i_operand_b,
    output logic                  o_q_valid,
    input  wire logic             i_q_ready,
    output fpa_pkg::t_op          o_q_data
);
    import fpa_pkg::*;
    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_op                 r_mem [DEPTH];
    logic [DEPTH_LOG2:0] r_wp, r_rp;
    t_op                 w_op;
    logic                w_push, w_pop;

    always_comb begin
        w_op.kind   = i_kind;
        w_op.is_div = (i_kind == OP_DIV);
        w_op.is_cmp = (i_kind == OP_GT) || (i_kind == OP_LT) || (i_kind == OP_GE) ||
                      (i_kind == OP_LE) || (i_kind == OP_EQ) || (i_kind == OP_NE);
        w_op.a = PORT_W'($signed(i_operand_a[DATA_WIDTH-1:0]));
        w_op.b = PORT_W'($signed(i_operand_b[DATA_WIDTH-1:0]));
    end

    assign o_ready   = (r_wp - r_rp) != (DEPTH_LOG2+1)'(DEPTH);
    assign o_q_valid = r_wp != r_rp;
    assign o_q_data  = r_mem[r_rp[DEPTH_LOG2-1:0]];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp[DEPTH_LOG2-1:0]] <= w_op;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- sv/fpa_div.sv -----
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
`default_nettype none
module fpa_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [31:0]    i_a,
    input  wire logic signed [31:0]    i_b,
    output logic                       o_done,
    output logic [63:0]                o_quot
);
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]        r_num, r_q;
    logic [DATA_WIDTH:0]  r_rem, r_den;
    logic                 r_neg, r_busy, r_done;
    logic [CW-1:0]        r_cnt;
    logic [DATA_WIDTH:0]  w_trial;
    logic [DATA_WIDTH+1:0] w_sh;
    logic signed [63:0]   w_a64, w_b64;

    assign w_a64 = 64'(i_a);
    assign w_b64 = 64'(i_b);
    assign w_sh  = {r_rem, r_num[NW-1]};
    assign w_trial = w_sh[DATA_WIDTH:0] - r_den;
    assign o_done = r_done;
    assign o_quot = r_neg ? 64'(-$signed({1'b0, r_q})) : 64'(r_q);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NW'((w_a64 < 0 ? -w_a64 : w_a64) << FRAC_BITS);
            r_den <= (DATA_WIDTH+1)'(w_b64 < 0 ? -w_b64 : w_b64);
            r_rem <= '0;
            r_neg <= (i_a < 0) != (i_b < 0);
            r_cnt <= CW'(NW);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_trial;
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DATA_WIDTH:0];
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // hold done until the next start so a stalled consumer cannot miss it
            if (i_start) r_done <= 1'b0;
            else if (r_busy && r_cnt == CW'(1)) r_done <= 1'b1;
            if (i_start) r_busy <= 1'b1;
            else if (r_busy && r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- sv/fpa_back.sv -----
// Back end: two-stage execute pipeline with a shared serial divider and output register.
`default_nettype none
module fpa_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    output logic             o_q_ready,
    input  wire fpa_pkg::t_op i_q_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output fpa_pkg::t_res    o_res
);
    import fpa_pkg::*;
    localparam int DW = DATA_WIDTH;

    // stage 1 registers
    logic              r_v1;
    t_op               r_op1;
    logic signed [63:0] r_wide1;
    logic              r_cmp1;
    // output register
    logic              r_v2;
    t_res              r_res2;

    logic         w_adv1, w_load1, w_div_wait;
    logic         w_div_done;
    logic [63:0]  w_quot;
    logic signed [63:0] w_a, w_b, w_wide, w_full;
    logic         w_cmp, w_dz, w_ovf, w_fits;
    t_res         w_res;

    assign w_a = 64'($signed(i_q_data.a));
    assign w_b = 64'($signed(i_q_data.b));

    // stage 2 is free when output register is empty or taken
    assign w_div_wait = r_v1 && r_op1.is_div && (r_op1.b[DW-1:0] != '0) && !w_div_done;
    assign w_adv1     = r_v1 && !w_div_wait && (!r_v2 || i_ready);
    assign w_load1    = !r_v1 || w_adv1;
    assign o_q_ready  = w_load1;

    always_comb begin
        w_wide = '0;
        w_cmp  = 1'b0;
        case (i_q_data.kind)
            OP_ADD: w_wide = w_a + w_b;
            OP_SUB: w_wide = w_a - w_b;
            OP_MUL: w_wide = w_a * w_b;
            OP_GT:  w_cmp = w_a > w_b;
            OP_LT:  w_cmp = w_a < w_b;
            OP_GE:  w_cmp = w_a >= w_b;
            OP_LE:  w_cmp = w_a <= w_b;
            OP_EQ:  w_cmp = w_a == w_b;
            OP_NE:  w_cmp = w_a != w_b;
            OP_MIN: w_wide = (w_a < w_b) ? w_a : w_b;
            OP_MAX: w_wide = (w_a > w_b) ? w_a : w_b;
            OP_INC: w_wide = w_a + 64'sd1;
            OP_DEC: w_wide = w_a - 64'sd1;
            OP_I2F: w_wide = w_a <<< FRAC_BITS;
            OP_F2I: w_wide = w_a >>> FRAC_BITS;
            default: w_wide = '0;
        endcase
    end

    fpa_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_load1 && i_q_valid && i_q_data.is_div && (i_q_data.b[DW-1:0] != '0)),
        .i_a     ($signed(i_q_data.a)),
        .i_b     ($signed(i_q_data.b)),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_dz   = 1'b0;
        w_full = r_wide1;
        if (r_op1.kind == OP_MUL) begin
            w_full = r_wide1 >>> FRAC_BITS;
        end else if (r_op1.is_div) begin
            w_dz   = r_op1.b[DW-1:0] == '0;
            w_full = w_dz ? 64'sd0 : $signed(w_quot);
        end
        w_fits = w_full == 64'($signed(w_full[DW-1:0]));
        w_ovf  = !r_op1.is_cmp && !w_fits;
        w_res.result = r_op1.is_cmp ? '0 : PORT_W'($signed(w_full[DW-1:0]));
        w_res.cmp    = r_cmp1;
        w_res.dz     = w_dz;
        w_res.ovf    = w_ovf;
    end

    assign o_valid = r_v2;
    assign o_res   = r_res2;

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_op1   <= i_q_data;
            r_wide1 <= w_wide;
            r_cmp1  <= w_cmp;
        end
        if (w_adv1) begin
            r_res2 <= w_res;
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_load1) r_v1 <= i_q_valid;
            if (w_adv1) r_v2 <= 1'b1;
            else if (i_ready) r_v2 <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- sv/fixed_point_alu_unit.sv -----
// Top level of the signed fixed-point ALU: front queue plus execute back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  input   | in        | i_valid / o_ready  | i_kind, i_operand_a, i_operand_b
//  result  | out       | o_valid / i_ready  | o_result, o_compare_true, o_div_by_zero,
//          |           |                    | o_overflow
//
// Non-divide transactions take one per cycle unless the result side stalls.
// A nonzero-divisor divide holds the execute stage until the serial radix-2 unit is done.
// A two-entry queue decouples acceptance from execute; the output register holds a
// result under stall while the front keeps taking transactions until the queue fills.
// Synchronous active-low reset empties queue and pipeline; no clearing pass.
`default_nettype none
module fixed_point_alu_unit #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [3:0]   i_kind,
    input  wire logic [31:0]  i_operand_a,
    input  wire logic [31:0]  i_operand_b,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [31:0]       o_result,
    output logic              o_compare_true,
    output logic              o_div_by_zero,
    output logic              o_overflow
);
    import fpa_pkg::*;

    logic w_q_valid, w_q_ready;
    t_op  w_q_data;
    t_res w_res;

    // accept and classify
    fpa_front #(.DATA_WIDTH(DATA_WIDTH), .DEPTH_LOG2(1)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_q_valid   (w_q_valid),
        .i_q_ready   (w_q_ready),
        .o_q_data    (w_q_data)
    );

    // execute and hold the result
    fpa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_data  (w_q_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_result       = w_res.result;
    assign o_compare_true = w_res.cmp;
    assign o_div_by_zero  = w_res.dz;
    assign o_overflow     = w_res.ovf;
endmodule
`default_nettype wire

// ----- sv/fpa_checker.sv -----
// Port-level checker for the fixed-point ALU, bound to the top level.
`default_nettype none
module fpa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_result,
    input wire logic        o_compare_true,
    input wire logic        o_div_by_zero,
    input wire logic        o_overflow
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result changed under stall");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_compare_true, o_div_by_zero, o_overflow}) <= 1)
        else $error("flags not exclusive");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result == 32'd0)
        else $error("comparison result not zero");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_result == 32'd0)
        else $error("divide by zero result not zero");
endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_result(o_result), .o_compare_true(o_compare_true),
    .o_div_by_zero(o_div_by_zero), .o_overflow(o_overflow)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Testbench for the fixed-point ALU: random bursty driver, stalling sink, field-level checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1700;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [31:0] result;
        logic        cmp;
        logic        dz;
        logic        ovf;
    } alu_res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_kind = '0;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result;
    logic        o_compare_true;
    logic        o_div_by_zero;
    logic        o_overflow;

    fixed_point_alu_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result(o_result), .o_compare_true(o_compare_true),
        .o_div_by_zero(o_div_by_zero), .o_overflow(o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    alu_op_t  pending_ops[$];
    alu_res_t expected_res[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_send = 1'b0;   // set by the stimulus to drain the block
    bit       timed_out = 1'b0;

    // Compute one ALU result the way the block should.
    function automatic alu_res_t alu_predict(alu_op_t op);
        logic signed [63:0] a, b, full, prod;
        bit arith;
        alu_res_t r;
        a = 64'(signed'(op.a));
        b = 64'(signed'(op.b));
        full = '0;
        arith = 1'b1;
        r = '0;
        case (op.kind)
            OP_ADD: full = a + b;
            OP_SUB: full = a - b;
            OP_MUL: begin
                prod = a * b;
                full = prod >>> FB;
            end
            OP_DIV: begin
                if (b == 0) r.dz = 1'b1;
                else full = (a <<< FB) / b;   // signed division truncates toward zero
            end
            OP_GT: begin r.cmp = a > b;  arith = 1'b0; end
            OP_LT: begin r.cmp = a < b;  arith = 1'b0; end
            OP_GE: begin r.cmp = a >= b; arith = 1'b0; end
            OP_LE: begin r.cmp = a <= b; arith = 1'b0; end
            OP_EQ: begin r.cmp = a == b; arith = 1'b0; end
            OP_NE: begin r.cmp = a != b; arith = 1'b0; end
            OP_MIN: full = (a < b) ? a : b;
            OP_MAX: full = (a > b) ? a : b;
            OP_INC: full = a + 1;
            OP_DEC: full = a - 1;
            OP_I2F: full = a <<< FB;
            default: full = a >>> FB;
        endcase
        if (arith) begin
            r.result = full[31:0];
            r.ovf = (full != 64'(signed'(full[31:0])));
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 8)) - 4);
            4: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< FB;
            5, 6: return 32'(signed'($urandom_range(0, 65535)) - 32768);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_op(logic [3:0] k, logic [31:0] a, logic [31:0] b);
        alu_op_t op;
        op.kind = k;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // Driver: bursts of random length with random gaps in between.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_res.push_back(alu_predict({i_kind, i_operand_a, i_operand_b}));
            end
            if (!i_valid || o_ready) begin
                // Previous transaction gone (or none); decide what to present next.
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_ops.size() > 0 && !hold_send) begin
                    alu_op_t op;
                    op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= op.kind;
                    i_operand_a <= op.a;
                    i_operand_b <= op.b;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern of its own, alternating open and choppy phases.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 200;
        if (!i_rst_n) i_ready <= 1'b0;
        else if (stall_phase < 60) i_ready <= 1'b1;
        else if (stall_phase < 140) i_ready <= ($urandom_range(0, 2) != 0);
        else i_ready <= ($urandom_range(0, 4) == 0);
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_res.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h", o_result);
            end else begin
                alu_res_t exp_r;
                exp_r = expected_res.pop_front();
                if (exp_r !== {o_result, o_compare_true, o_div_by_zero, o_overflow}) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch exp %h/%b%b%b got %h/%b%b%b",
                                 exp_r.result, exp_r.cmp, exp_r.dz, exp_r.ovf,
                                 o_result, o_compare_true, o_div_by_zero, o_overflow);
                end
            end
        end
    end

    initial begin
        logic [3:0] k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every opcode, operand extremes, zero divisor, ties, wraps.
        for (int op = 0; op < 16; op++) add_op(4'(op), 32'h7fff_ffff, 32'h8000_0000);
        add_op(OP_DIV, 32'h0000_0500, 32'h0);
        add_op(OP_DIV, 32'hffff_fb00, 32'h0000_0300);
        add_op(OP_MIN, 32'd77, 32'd77);
        add_op(OP_MAX, 32'hffff_ff00, 32'hffff_ff00);
        add_op(OP_INC, 32'h7fff_ffff, 32'h0);
        add_op(OP_DEC, 32'h8000_0000, 32'h0);
        add_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        add_op(OP_F2I, 32'hffff_ff01, 32'h0);
        add_op(OP_I2F, 32'h0080_0000, 32'h0);

        for (int i = 0; i < N_RANDOM; i++) begin
            k = 4'($urandom_range(0, 15));
            add_op(k, rand_word(), ($urandom_range(0, 19) == 0) ? 32'h0 : rand_word());
            if (i == N_RANDOM / 2) begin
                // Drain: hold the sender until every result is back.
                wait (pending_ops.size() == 0);
                hold_send = 1'b1;
                wait (!i_valid && expected_res.size() == 0);
                hold_send = 1'b0;
            end
        end
        wait (pending_ops.size() == 0 && !i_valid && expected_res.size() == 0);
        repeat (60) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || cycles >= CYCLE_CAP);
        if (!stim_done) timed_out = 1'b1;
        if (!timed_out && mismatches == 0 && expected_res.size() == 0) begin
            $display("fixed_point_alu_unit: match");
        end else begin
            $display("fixed_point_alu_unit: mismatch");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/fpa_pkg.sv
sv/fpa_front.sv
sv/fpa_div.sv
sv/fpa_back.sv
sv/fixed_point_alu_unit.sv
sv/fpa_checker.sv
tb/sv/tb.sv
